// File: hdl/dlz_pkg.sv
// Shared constants and types for the LZ stream decompressor.
package dlz_pkg;
    localparam int WINDOW_BYTES     = 8192;
    localparam int WIN_BITS         = $clog2(WINDOW_BYTES);
    localparam int BYTES_PER_RESULT = 8;
    localparam int LENGTH_BITS      = 22;

    localparam logic [3:0] BPR = 4'(BYTES_PER_RESULT);

    // Command codes passed from the token decoder to the copy engine.
    localparam logic [1:0] CMD_LIT  = 2'd0;
    localparam logic [1:0] CMD_COPY = 2'd1;
    localparam logic [1:0] CMD_STOP = 2'd2;
    localparam logic [1:0] CMD_NONE = 2'd3;

    typedef struct packed {
        logic [1:0]          kind;
        logic [7:0]          lit;
        logic [WIN_BITS:0]   distance;
        logic [8:0]          len;
    } dlz_cmd_t;
endpackage

// File: hdl/dlz_in_if.sv
// Input channel and result channel interfaces.
interface dlz_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       stream_start;
    modport source (output valid, output data_byte, output stream_start, input ready);
    modport sink (input valid, input data_byte, input stream_start, output ready);
endinterface

interface dlz_out_if;
    logic        valid;
    logic        ready;
    logic [63:0] out_bytes;
    logic [3:0]  byte_count;
    logic        last_of_run;
    logic        stream_end;
    logic [21:0] total_length;
    modport source (output valid, output out_bytes, output byte_count, output last_of_run,
                    output stream_end, output total_length, input ready);
    modport sink (input valid, input out_bytes, input byte_count, input last_of_run,
                  input stream_end, input total_length, output ready);
endinterface

// File: hdl/dlz_front.sv
// Token decoder: shifts control bits one per cycle unless stalled; issues commands.
module dlz_front
    import dlz_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    dlz_in_if.sink   in_ch,
    output logic     cmd_valid,
    output dlz_cmd_t cmd,
    input  logic     cmd_ready
);
    localparam logic [4:0] PH_TOKEN = 5'd0,  PH_X2 = 5'd1, PH_LIT = 5'd2,
        PH_V_SHORT = 5'd3, PH_S_A1 = 5'd4, PH_S_HI = 5'd5, PH_S_SPECIAL = 5'd6,
        PH_V_LONG = 5'd7, PH_L_A1 = 5'd8, PH_L_A2 = 5'd9, PH_L_A3 = 5'd10,
        PH_L_A4 = 5'd11, PH_L_A5 = 5'd12, PH_L_A6 = 5'd13, PH_L_A7 = 5'd14,
        PH_L_A8 = 5'd15, PH_LEN_UNARY = 5'd16, PH_LEN_X1 = 5'd17, PH_LEN_X2 = 5'd18,
        PH_LEN_3 = 5'd19, PH_LEN_BYTE = 5'd20, PH_DONE = 5'd21;

    logic [4:0]  phase_reg, phase_next;
    logic [15:0] cw_reg, cw_next;
    logic [4:0]  left_reg, left_next;
    logic        hi_reg, hi_next;
    logic [7:0]  dlo_reg, dlo_next;
    logic [4:0]  dhi_reg, dhi_next;
    logic [WIN_BITS:0] dist_reg, dist_next;
    logic [8:0]  lbs_reg, lbs_next;
    logic        busy_reg, busy_next;   // still consuming control bits
    logic        cmd_valid_reg, cmd_valid_next;
    dlz_cmd_t    cmd_reg, cmd_next;
    logic        b, stall;
    logic [4:0]  p0;
    logic [15:0] ldbase;
    logic [12:0] dhl;

    assign stall = cmd_valid_reg && !cmd_ready;
    assign in_ch.ready = !busy_reg && !stall;
    assign cmd_valid = cmd_valid_reg;
    assign cmd = cmd_reg;
    assign b = cw_reg[0];
    assign dhl = {dhi_reg, dlo_reg};

    always_comb
    begin
        phase_next = phase_reg; cw_next = cw_reg; left_next = left_reg;
        hi_next = hi_reg; dlo_next = dlo_reg; dhi_next = dhi_reg;
        dist_next = dist_reg; lbs_next = lbs_reg; busy_next = busy_reg;
        cmd_valid_next = stall; cmd_next = cmd_reg;
        ldbase = '0; p0 = phase_reg;
        if (in_ch.valid && in_ch.ready) begin
            if (in_ch.stream_start) begin
                p0 = PH_TOKEN; left_next = '0; hi_next = 1'b0;
                dlo_next = '0; dhi_next = '0; dist_next = '0; lbs_next = '0;
                cw_next = '0;
            end
            cmd_valid_next = 1'b1;
            cmd_next = '{kind: CMD_NONE, lit: 8'd0, distance: '0, len: 9'd0};
            cmd_next.lit = {7'd0, in_ch.stream_start};
            phase_next = p0;
            if (p0 != PH_DONE) begin
                if (!(in_ch.stream_start ? 1'b0 : (left_reg != 5'd0))) begin
                    if (!(in_ch.stream_start ? 1'b0 : hi_reg)) begin
                        cw_next = {8'd0, in_ch.data_byte}; hi_next = 1'b1;
                    end else begin
                        cw_next = {in_ch.data_byte, cw_reg[7:0]}; hi_next = 1'b0;
                        left_next = 5'd16; busy_next = 1'b1; cmd_valid_next = 1'b0;
                    end
                end else begin
                    busy_next = 1'b1; cmd_valid_next = 1'b0;
                    unique case (p0)
                        PH_LIT:
                        begin
                            cmd_next.kind = CMD_LIT; cmd_next.lit = in_ch.data_byte;
                            cmd_valid_next = 1'b1; phase_next = PH_TOKEN;
                        end
                        PH_V_SHORT: begin dlo_next = in_ch.data_byte; phase_next = PH_S_A1; end
                        PH_V_LONG:  begin dlo_next = in_ch.data_byte; phase_next = PH_L_A1; end
                        PH_LEN_BYTE:
                        begin
                            cmd_next.kind = CMD_COPY; cmd_next.distance = dist_reg;
                            cmd_next.len = 9'd17 + {1'b0, in_ch.data_byte};
                            cmd_valid_next = 1'b1; phase_next = PH_TOKEN;
                        end
                        default: ;
                    endcase
                end
            end
        end else if (busy_reg && !stall) begin
            if (left_reg == 5'd0 || phase_reg == PH_LIT || phase_reg == PH_V_SHORT ||
                phase_reg == PH_V_LONG || phase_reg == PH_LEN_BYTE || phase_reg == PH_DONE)
            begin
                busy_next = 1'b0;
                // End of this byte's work: marks the run so results get last_of_run.
                cmd_valid_next = 1'b1;
                cmd_next = '{kind: CMD_NONE, lit: 8'd0, distance: '0, len: 9'd0};
            end else begin
                cw_next = {1'b0, cw_reg[15:1]}; left_next = left_reg - 5'd1;
                cmd_next = '{kind: CMD_COPY, lit: 8'd0, distance: dist_reg, len: 9'd2};
                unique case (phase_reg)
                    PH_TOKEN: phase_next = b ? PH_LIT : PH_X2;
                    PH_X2: phase_next = b ? PH_V_LONG : PH_V_SHORT;
                    PH_S_A1:
                        if (b) begin
                            dhi_next = '0; lbs_next = '0; phase_next = PH_S_HI;
                        end else if (dlo_reg != 8'hff) begin
                            cmd_next.distance = (WIN_BITS+1)'(9'd256 - {1'b0, dlo_reg});
                            cmd_valid_next = 1'b1; phase_next = PH_TOKEN;
                        end else phase_next = PH_S_SPECIAL;
                    PH_S_HI:
                    begin
                        dhi_next = {2'd0, dhi_reg[1:0], b};
                        lbs_next = lbs_reg + 9'd1;
                        if (lbs_reg >= 9'd2) begin
                            cmd_next.distance = (WIN_BITS+1)'(16'd2304 -
                                {5'd0, dhi_reg[1:0], b, dlo_reg});
                            cmd_valid_next = 1'b1; phase_next = PH_TOKEN;
                        end
                    end
                    PH_S_SPECIAL:
                        if (b) phase_next = PH_TOKEN;
                        else begin
                            cmd_next.kind = CMD_STOP; cmd_valid_next = 1'b1;
                            phase_next = PH_DONE; busy_next = 1'b0;
                        end
                    PH_L_A1: begin dhi_next = {4'd0, b}; phase_next = PH_L_A2; end
                    PH_L_A2: if (b) ldbase = 16'd511; else phase_next = PH_L_A3;
                    PH_L_A3: if (b) ldbase = 16'd1023; else phase_next = PH_L_A4;
                    PH_L_A4: begin dhi_next = {3'd0, dhi_reg[0], b}; phase_next = PH_L_A5; end
                    PH_L_A5: if (b) ldbase = 16'd2047; else phase_next = PH_L_A6;
                    PH_L_A6: begin dhi_next = {2'd0, dhi_reg[1:0], b}; phase_next = PH_L_A7; end
                    PH_L_A7: if (b) ldbase = 16'd4095; else phase_next = PH_L_A8;
                    PH_L_A8: ldbase = 16'd8191;
                    PH_LEN_UNARY:
                    begin
                        lbs_next = lbs_reg + 9'd1;
                        if (b) begin
                            cmd_next.len = 9'd3 + lbs_reg; cmd_valid_next = 1'b1;
                            phase_next = PH_TOKEN;
                        end else if (lbs_reg >= 9'd3) phase_next = PH_LEN_X1;
                    end
                    PH_LEN_X1: begin lbs_next = {8'd0, b}; phase_next = PH_LEN_X2; end
                    PH_LEN_X2:
                        if (lbs_reg[0]) begin
                            cmd_next.len = 9'd7 + {8'd0, b}; cmd_valid_next = 1'b1;
                            phase_next = PH_TOKEN;
                        end else if (!b) begin
                            lbs_next = 9'd1; phase_next = PH_LEN_3;
                        end else phase_next = PH_LEN_BYTE;
                    PH_LEN_3:
                    begin
                        lbs_next = {5'd0, lbs_reg[2:0], b};
                        if (lbs_reg[2]) begin
                            cmd_next.len = 9'd9 + {6'd0, lbs_reg[1:0], b};
                            cmd_valid_next = 1'b1; phase_next = PH_TOKEN;
                        end
                    end
                    default: ;
                endcase
                if (phase_reg == PH_L_A8) begin
                    dist_next = (WIN_BITS+1)'(ldbase - {4'd0, dhi_reg[2:0], b, dlo_reg} + 16'd1);
                    lbs_next = '0; phase_next = PH_LEN_UNARY;
                end else if (ldbase != 16'd0) begin
                    dist_next = (WIN_BITS+1)'(ldbase - {3'd0, dhl} + 16'd1);
                    lbs_next = '0; phase_next = PH_LEN_UNARY;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            phase_reg <= PH_TOKEN; cw_reg <= '0; left_reg <= '0; hi_reg <= 1'b0;
            dlo_reg <= '0; dhi_reg <= '0; dist_reg <= '0; lbs_reg <= '0;
            busy_reg <= 1'b0; cmd_valid_reg <= 1'b0;
        end else begin
            phase_reg <= phase_next; cw_reg <= cw_next; left_reg <= left_next;
            hi_reg <= hi_next; dlo_reg <= dlo_next; dhi_reg <= dhi_next;
            dist_reg <= dist_next; lbs_reg <= lbs_next; busy_reg <= busy_next;
            cmd_valid_reg <= cmd_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg <= cmd_next;
    end

`ifndef SYNTHESIS
    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_valid && !cmd_ready |=> cmd_valid && $stable(cmd)) else $error("cmd dropped");
    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> !in_ch.ready) else $error("accepted while busy");
    a_bits_bound: assert property (@(posedge clk) disable iff (!rst_n)
        left_reg <= 5'd16) else $error("control bit count");
`endif
endmodule

// File: hdl/dlz_queue.sv
// Short command queue between the token decoder and the copy engine.
module dlz_queue
    import dlz_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     wr_valid,
    input  dlz_cmd_t wr_cmd,
    output logic     wr_ready,
    output logic     rd_valid,
    output dlz_cmd_t rd_cmd,
    input  logic     rd_ready
);
    dlz_cmd_t  mem_reg [4];
    logic [1:0] wp_reg, rp_reg;
    logic [2:0] cnt_reg;
    logic wr, rd;

    assign wr_ready = cnt_reg != 3'd4;
    assign rd_valid = cnt_reg != 3'd0;
    assign rd_cmd = mem_reg[rp_reg];
    assign wr = wr_valid && wr_ready;
    assign rd = rd_valid && rd_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wp_reg <= '0; rp_reg <= '0; cnt_reg <= '0;
        end else begin
            if (wr) wp_reg <= wp_reg + 2'd1;
            if (rd) rp_reg <= rp_reg + 2'd1;
            cnt_reg <= cnt_reg + {2'd0, wr} - {2'd0, rd};
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr) mem_reg[wp_reg] <= wr_cmd;
    end

`ifndef SYNTHESIS
    a_count: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= 3'd4) else $error("queue count");
    a_full: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg == 3'd4 && !rd |=> cnt_reg == 3'd4) else $error("queue full lost");
    a_empty: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg == 3'd0 && !wr |=> cnt_reg == 3'd0) else $error("queue empty");
`endif
endmodule

// File: hdl/dlz_back.sv
// Copy engine: writes the history window and packs bytes into result groups.
module dlz_back
    import dlz_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     cmd_valid,
    input  dlz_cmd_t cmd,
    output logic     cmd_ready,
    dlz_out_if.source out_ch
);
    logic [7:0] win_mem [WINDOW_BYTES];
    logic [7:0] rd_data_reg;
    logic [LENGTH_BITS-1:0] pos_reg;
    logic [8:0] rem_reg;               // bytes still to copy
    logic [WIN_BITS:0] dist_reg;
    logic rd_pend_reg;                 // a read or literal byte waits to be written
    logic [63:0] grp_reg;
    logic [3:0]  gcnt_reg;
    logic        pend_reg;             // a group has bytes since the last result
    logic        ov_reg;
    logic [63:0] ob_reg;
    logic [3:0]  oc_reg;
    logic        ol_reg, oe_reg;
    logic [LENGTH_BITS-1:0] otl_reg;
    logic        copying, emit_now, can_out, idle;
    logic        full, flush_full, flush_stop;
    logic [7:0]  eb;
    logic [WIN_BITS-1:0] raddr;

    assign can_out = !ov_reg || out_ch.ready;
    assign copying = rem_reg != 9'd0;
    assign idle = !copying && !rd_pend_reg;
    assign full = gcnt_reg == BPR;
    // A full group leaves as soon as more bytes follow; the end-of-byte marker
    // takes it itself so that it carries last_of_run.
    assign flush_full = full && can_out &&
                        (copying || rd_pend_reg || (cmd_valid && cmd.kind != CMD_NONE));
    // Bytes ahead of a stop code leave in their own result before the stop report.
    assign flush_stop = idle && can_out && cmd_valid && cmd.kind == CMD_STOP && pend_reg;
    assign cmd_ready = idle && can_out && (!full || cmd.kind == CMD_NONE) &&
                       !(cmd.kind == CMD_STOP && pend_reg);
    assign raddr = WIN_BITS'(pos_reg - LENGTH_BITS'(dist_reg) +
                   (rd_pend_reg ? LENGTH_BITS'(1) : LENGTH_BITS'(0)));
    assign emit_now = rd_pend_reg && gcnt_reg != BPR;
    assign eb = rd_data_reg;

    assign out_ch.valid = ov_reg;
    assign out_ch.out_bytes = ob_reg;
    assign out_ch.byte_count = oc_reg;
    assign out_ch.last_of_run = ol_reg;
    assign out_ch.stream_end = oe_reg;
    assign out_ch.total_length = otl_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            pos_reg <= '0; rem_reg <= '0; rd_pend_reg <= 1'b0; gcnt_reg <= '0;
            pend_reg <= 1'b0; ov_reg <= 1'b0;
        end else begin
            if (ov_reg && out_ch.ready) ov_reg <= 1'b0;
            if (flush_full || flush_stop) begin
                ov_reg <= 1'b1; ob_reg <= grp_reg; oc_reg <= gcnt_reg; ol_reg <= 1'b0;
                oe_reg <= 1'b0; otl_reg <= pos_reg; gcnt_reg <= '0; grp_reg <= '0;
                pend_reg <= 1'b0;
            end else if (emit_now) begin
                win_mem[WIN_BITS'(pos_reg)] <= eb;
                grp_reg[8*gcnt_reg[2:0] +: 8] <= eb;
                gcnt_reg <= gcnt_reg + 4'd1; pend_reg <= 1'b1;
                pos_reg <= pos_reg + LENGTH_BITS'(1);
                rd_pend_reg <= 1'b0;
            end else if (copying && !rd_pend_reg) begin
                rd_data_reg <= win_mem[raddr];
                rd_pend_reg <= 1'b1; rem_reg <= rem_reg - 9'd1;
            end else if (cmd_valid && cmd_ready) begin
                unique case (cmd.kind) inside
                    CMD_LIT:
                    begin
                        rd_data_reg <= cmd.lit; rd_pend_reg <= 1'b1;
                    end
                    CMD_COPY:
                    begin
                        rem_reg <= cmd.len; dist_reg <= cmd.distance;
                    end
                    CMD_STOP, CMD_NONE:
                    begin
                        // Stream restart clears the position before any output.
                        if (cmd.kind == CMD_NONE && cmd.lit[0]) begin
                            pos_reg <= '0;
                        end else if (cmd.kind == CMD_STOP || pend_reg) begin
                            ov_reg <= 1'b1;
                            ob_reg <= cmd.kind == CMD_STOP ? 64'd0 : grp_reg;
                            oc_reg <= cmd.kind == CMD_STOP ? 4'd0 : gcnt_reg;
                            ol_reg <= 1'b1; oe_reg <= cmd.kind == CMD_STOP;
                            otl_reg <= pos_reg;
                            gcnt_reg <= '0; grp_reg <= '0; pend_reg <= 1'b0;
                        end
                    end
                    default: ;
                endcase
            end
        end
    end

`ifndef SYNTHESIS
    a_gcnt: assert property (@(posedge clk) disable iff (!rst_n)
        gcnt_reg <= BPR) else $error("group overflow");
    a_stop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        ov_reg && oe_reg |-> oc_reg == 4'd0) else $error("stop result has bytes");
    a_no_cmd_copy: assert property (@(posedge clk) disable iff (!rst_n)
        copying |-> !cmd_ready) else $error("cmd taken mid-copy");
`endif
endmodule

// File: hdl/diet_lz_stream_decompressor_core.sv
// LZ stream decompressor: top level joining token decoder, queue and copy engine.
// Takes one compressed byte per transaction (header removed) and returns up to eight
// decompressed bytes per result transaction, the last result of each byte marked.
// The token decoder accepts a byte, then consumes the control bits it holds in turn
// (up to 16 after the control word's high byte) and closes its work before it accepts
// the next byte. The copy engine reads each copied byte from the single-port 8 KiB
// window, writes every output byte back into it and packs the bytes into groups of
// eight. A four-entry command queue lets the decoder run ahead while the copy engine
// works.
module diet_lz_stream_decompressor_core
    import dlz_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    dlz_in_if.sink    in_ch,
    dlz_out_if.source out_ch
);
    logic     f_valid, f_ready, b_valid, b_ready;
    dlz_cmd_t f_cmd, b_cmd;

    dlz_front u_front (.clk, .rst_n, .in_ch, .cmd_valid(f_valid), .cmd(f_cmd),
                       .cmd_ready(f_ready));
    dlz_queue u_queue (.clk, .rst_n, .wr_valid(f_valid), .wr_cmd(f_cmd), .wr_ready(f_ready),
                       .rd_valid(b_valid), .rd_cmd(b_cmd), .rd_ready(b_ready));
    dlz_back u_back (.clk, .rst_n, .cmd_valid(b_valid), .cmd(b_cmd), .cmd_ready(b_ready),
                     .out_ch);
endmodule

// File: test/tb_diet_lz_stream_decompressor_core.sv
// Self-checking testbench for the LZ stream decompressor core.
module tb_diet_lz_stream_decompressor_core;
    import dlz_pkg::*;

    localparam int WMASK = WINDOW_BYTES - 1;
    localparam int IDLE_LIMIT = 5000;
    localparam int TARGET_ITEMS = 425;

    typedef enum int {
        P_TOKEN, P_X2, P_LIT, P_V_SHORT, P_S_A1, P_S_HI, P_S_SPECIAL, P_V_LONG,
        P_L_A1, P_L_A2, P_L_A3, P_L_A4, P_L_A5, P_L_A6, P_L_A7, P_L_A8,
        P_LEN_UNARY, P_LEN_X1, P_LEN_X2, P_LEN_3, P_LEN_BYTE, P_DONE
    } phase_t;

    typedef struct {
        logic [7:0] data;
        logic       start;
        logic       drain;
    } in_item_t;

    typedef struct {
        logic [63:0] bytes;
        logic [3:0]  cnt;
        logic        last;
        logic        fin;
        logic [21:0] total;
    } group_t;

    logic clk;
    logic rst_n;
    dlz_in_if  in_bus();
    dlz_out_if out_bus();

    diet_lz_stream_decompressor_core u_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_bus),
        .out_ch (out_bus)
    );

    in_item_t   byte_q[$];
    group_t     group_q[$];
    logic       in_fire;
    int         errors;
    int         bytes_sent;
    int         groups_seen;
    int         stops_seen;
    int         streams_built;
    int         idle_cycles;
    int         hold_left;
    bit         hold_done;

    // Decoder state mirrored for prediction.
    logic [7:0]  win[WINDOW_BYTES];
    logic [21:0] opos;
    logic [15:0] cword;
    int          cleft;
    bit          chigh;
    phase_t      ph;
    int          dlo;
    int          dhi;
    int          mdist;
    int          lseen;
    logic [7:0]  burst[$];
    bit          stop_hit;

    // Encoder side: bytes of the stream being built and the window entries written so far.
    logic [7:0]  sbuf[$];
    int          slot;
    logic [15:0] ebits;
    int          ecnt;
    int          epos;
    bit          ewr[WINDOW_BYTES];

    initial begin
        clk = 1'b0;
        forever
        begin
            #5 clk = 1'b1;
            #5 clk = 1'b0;
        end
    end

    function automatic int pct_send();
        if (bytes_sent < 150) return 25;
        if (bytes_sent < 300) return 45;
        return 0;
    endfunction

    function automatic int pct_recv();
        if (bytes_sent < 150) return 45;
        if (bytes_sent < 300) return 25;
        return 0;
    endfunction

    // ---------------- predictor ----------------
    function automatic void dec_restart();
        opos = '0;
        cword = '0;
        cleft = 0;
        chigh = 1'b0;
        ph = P_TOKEN;
        dlo = 0;
        dhi = 0;
        mdist = 0;
        lseen = 0;
    endfunction

    function automatic void dec_put(logic [7:0] b);
        win[opos & WMASK] = b;
        burst.push_back(b);
        opos = opos + 22'd1;
    endfunction

    function automatic void dec_copy(int span, int len);
        for (int i = 0; i < len; i++)
            dec_put(win[(int'(opos) - span) & WMASK]);
        ph = P_TOKEN;
    endfunction

    function automatic void dec_long(int base);
        mdist = base - (dhi * 256 + dlo) + 1;
        lseen = 0;
        ph = P_LEN_UNARY;
    endfunction

    function automatic void dec_bits();
        int b;
        while (cleft > 0)
        begin
            if (ph inside {P_LIT, P_V_SHORT, P_V_LONG, P_LEN_BYTE, P_DONE})
                return;
            b = cword[0];
            cword = cword >> 1;
            cleft--;
            case (ph)
                P_TOKEN: ph = b ? P_LIT : P_X2;
                P_X2:    ph = b ? P_V_LONG : P_V_SHORT;
                P_S_A1:
                    if (b)
                    begin
                        dhi = 0;
                        lseen = 0;
                        ph = P_S_HI;
                    end
                    else if (dlo != 8'hff)
                        dec_copy(256 - dlo, 2);
                    else
                        ph = P_S_SPECIAL;
                P_S_HI:
                begin
                    dhi = ((dhi << 1) | b) & 7;
                    lseen++;
                    if (lseen >= 3)
                        dec_copy(2304 - (dhi * 256 + dlo), 2);
                end
                P_S_SPECIAL:
                    if (b)
                        ph = P_TOKEN;
                    else
                    begin
                        ph = P_DONE;
                        stop_hit = 1'b1;
                        return;
                    end
                P_L_A1: begin dhi = b; ph = P_L_A2; end
                P_L_A2: if (b) dec_long(511); else ph = P_L_A3;
                P_L_A3: if (b) dec_long(1023); else ph = P_L_A4;
                P_L_A4: begin dhi = ((dhi << 1) | b) & 3; ph = P_L_A5; end
                P_L_A5: if (b) dec_long(2047); else ph = P_L_A6;
                P_L_A6: begin dhi = ((dhi << 1) | b) & 7; ph = P_L_A7; end
                P_L_A7: if (b) dec_long(4095); else ph = P_L_A8;
                P_L_A8:
                begin
                    dhi = ((dhi << 1) | b) & 15;
                    dec_long(8191);
                end
                P_LEN_UNARY:
                begin
                    lseen++;
                    if (b)
                        dec_copy(mdist, 2 + lseen);
                    else if (lseen >= 4)
                        ph = P_LEN_X1;
                end
                P_LEN_X1: begin lseen = b; ph = P_LEN_X2; end
                P_LEN_X2:
                    if (lseen & 1)
                        dec_copy(mdist, 7 + b);
                    else if (b == 0)
                    begin
                        lseen = 1;
                        ph = P_LEN_3;
                    end
                    else
                        ph = P_LEN_BYTE;
                P_LEN_3:
                begin
                    lseen = ((lseen << 1) | b) & 15;
                    if (lseen >= 8)
                        dec_copy(mdist, 9 + (lseen & 7));
                end
                default: return;
            endcase
        end
    endfunction

    function automatic void predict_groups(logic [7:0] b, logic st);
        logic [21:0] pos0;
        group_t      g;
        int          n;
        int          first;
        burst.delete();
        stop_hit = 1'b0;
        if (st)
            dec_restart();
        pos0 = opos;
        if (ph == P_DONE)
            return;
        if (cleft == 0)
        begin
            if (!chigh)
            begin
                cword = {8'h00, b};
                chigh = 1'b1;
            end
            else
            begin
                cword[15:8] = b;
                chigh = 1'b0;
                cleft = 16;
                dec_bits();
            end
        end
        else
        begin
            case (ph)
                P_LIT:      begin dec_put(b); ph = P_TOKEN; end
                P_V_SHORT:  begin dlo = b; ph = P_S_A1; end
                P_V_LONG:   begin dlo = b; ph = P_L_A1; end
                P_LEN_BYTE: dec_copy(mdist, 17 + b);
                default: ;
            endcase
            dec_bits();
        end
        first = group_q.size();
        for (int off = 0; off < burst.size(); off += BYTES_PER_RESULT)
        begin
            n = burst.size() - off;
            if (n > BYTES_PER_RESULT)
                n = BYTES_PER_RESULT;
            g.bytes = '0;
            for (int k = 0; k < n; k++)
                g.bytes[8*k +: 8] = burst[off + k];
            g.cnt = 4'(n);
            g.last = 1'b0;
            g.fin = 1'b0;
            g.total = pos0 + 22'(off + n);
            group_q.push_back(g);
        end
        if (stop_hit)
        begin
            g.bytes = '0;
            g.cnt = '0;
            g.last = 1'b0;
            g.fin = 1'b1;
            g.total = opos;
            group_q.push_back(g);
        end
        if (group_q.size() > first)
            group_q[group_q.size() - 1].last = 1'b1;
    endfunction

    // ---------------- stream encoder ----------------
    function automatic void enc_begin();
        sbuf.delete();
        slot = 0;
        sbuf.push_back(8'h00);
        sbuf.push_back(8'h00);
        ebits = '0;
        ecnt = 0;
    endfunction

    // A fresh control word is placed as soon as the current one is full, ahead of
    // any data byte, since that is where the decoder fetches it.
    function automatic void enc_bit(int b);
        ebits[ecnt] = b[0];
        ecnt++;
        if (ecnt == 16)
        begin
            sbuf[slot] = ebits[7:0];
            sbuf[slot + 1] = ebits[15:8];
            slot = sbuf.size();
            sbuf.push_back(8'h00);
            sbuf.push_back(8'h00);
            ebits = '0;
            ecnt = 0;
        end
    endfunction

    function automatic void enc_mark(int len);
        for (int i = 0; i < len; i++)
            ewr[(epos + i) & WMASK] = 1'b1;
        epos += len;
    endfunction

    function automatic void tok_lit(logic [7:0] b);
        enc_bit(1);
        sbuf.push_back(b);
        enc_mark(1);
    endfunction

    function automatic void tok_escape(int s);
        enc_bit(0);
        enc_bit(0);
        sbuf.push_back(8'hff);
        enc_bit(0);
        enc_bit(s);
    endfunction

    function automatic void tok_match(int d, int len);
        int x;
        enc_bit(0);
        if (len == 2)
        begin
            enc_bit(0);
            if (d <= 256)
            begin
                sbuf.push_back(8'(256 - d));
                enc_bit(0);
            end
            else
            begin
                x = 2304 - d;
                sbuf.push_back(8'(x));
                enc_bit(1);
                enc_bit(x >> 10);
                enc_bit(x >> 9);
                enc_bit(x >> 8);
            end
        end
        else
        begin
            enc_bit(1);
            if (d <= 512) x = 512 - d;
            else if (d <= 1024) x = 1024 - d;
            else if (d <= 2048) x = 2048 - d;
            else if (d <= 4096) x = 4096 - d;
            else x = 8192 - d;
            sbuf.push_back(8'(x));
            if (d <= 512)
            begin
                enc_bit(x >> 8); enc_bit(1);
            end
            else if (d <= 1024)
            begin
                enc_bit(x >> 8); enc_bit(0); enc_bit(1);
            end
            else if (d <= 2048)
            begin
                enc_bit(x >> 9); enc_bit(0); enc_bit(0); enc_bit(x >> 8); enc_bit(1);
            end
            else if (d <= 4096)
            begin
                enc_bit(x >> 10); enc_bit(0); enc_bit(0); enc_bit(x >> 9); enc_bit(0);
                enc_bit(x >> 8); enc_bit(1);
            end
            else
            begin
                enc_bit(x >> 11); enc_bit(0); enc_bit(0); enc_bit(x >> 10); enc_bit(0);
                enc_bit(x >> 9); enc_bit(0); enc_bit(x >> 8);
            end
            if (len <= 6)
            begin
                for (int i = 3; i < len; i++)
                    enc_bit(0);
                enc_bit(1);
            end
            else
            begin
                repeat (4) enc_bit(0);
                if (len <= 8)
                begin
                    enc_bit(1);
                    enc_bit(len - 7);
                end
                else if (len <= 16)
                begin
                    enc_bit(0);
                    enc_bit(0);
                    enc_bit((len - 9) >> 2);
                    enc_bit((len - 9) >> 1);
                    enc_bit(len - 9);
                end
                else
                begin
                    enc_bit(0);
                    enc_bit(1);
                    sbuf.push_back(8'(len - 17));
                end
            end
        end
        enc_mark(len);
    endfunction

    // A copy may only read entries written since reset, counting its own output.
    function automatic bit dist_ok(int d, int len);
        for (int i = 0; i < len && i < d; i++)
            if (!ewr[(epos - d + i) & WMASK])
                return 1'b0;
        return 1'b1;
    endfunction

    function automatic void enc_commit(bit st, bit drain);
        in_item_t it;
        if (ecnt == 0 && slot == sbuf.size() - 2)
        begin
            void'(sbuf.pop_back());
            void'(sbuf.pop_back());
        end
        else
        begin
            sbuf[slot] = ebits[7:0];
            sbuf[slot + 1] = ebits[15:8];
        end
        foreach (sbuf[i])
        begin
            it.data = sbuf[i];
            it.start = st && (i == 0);
            it.drain = drain && (i == 0);
            byte_q.push_back(it);
        end
        streams_built++;
    endfunction

    function automatic int pick_len();
        int r;
        r = $urandom_range(99);
        if (r < 20) return 2;
        if (r < 50) return $urandom_range(3, 6);
        if (r < 65) return $urandom_range(7, 8);
        if (r < 82) return $urandom_range(9, 16);
        if (r < 96) return $urandom_range(17, 40);
        return $urandom_range(41, 272);
    endfunction

    function automatic void random_token();
        int len;
        int d;
        int r;
        r = $urandom_range(99);
        if (r < 3)
        begin
            tok_escape(1);
            return;
        end
        if (r < 40)
        begin
            tok_lit(8'($urandom));
            return;
        end
        len = pick_len();
        for (int tries = 0; tries < 8; tries++)
        begin
            if ($urandom_range(1))
                d = $urandom_range(1, 16);
            else
                d = $urandom_range(1, len == 2 ? 2304 : 8192);
            if (len == 2 && d < 2)
                d = 2;
            if (dist_ok(d, len))
            begin
                tok_match(d, len);
                return;
            end
        end
        tok_lit(8'($urandom));
    endfunction

    // ---------------- stimulus ----------------
    initial begin
        in_item_t junk;
        int r;
        int cnt;
        errors = 0;
        bytes_sent = 0;
        groups_seen = 0;
        stops_seen = 0;
        streams_built = 0;
        epos = 0;
        foreach (ewr[i])
            ewr[i] = 1'b0;
        foreach (win[i])
            win[i] = 8'h00;
        dec_restart();
        rst_n = 1'b0;
        in_bus.valid = 1'b0;
        in_bus.data_byte = 8'h00;
        in_bus.stream_start = 1'b0;
        out_bus.ready = 1'b0;

        // Directed stream, sent without a start flag right after reset.
        enc_begin();
        tok_lit(8'h00);
        tok_lit(8'hff);
        tok_lit(8'h5a);
        tok_lit(8'ha5);
        tok_match(2, 2);
        tok_match(1, 3);
        tok_match(1, 7);
        tok_match(3, 9);
        tok_match(1, 16);
        tok_match(5, 17);
        tok_match(1, 272);
        tok_escape(1);
        tok_match(4, 6);
        tok_escape(0);
        enc_commit(1'b0, 1'b0);
        // Bytes after the stop code are ignored.
        junk.data = 8'h3c;
        junk.start = 1'b0;
        junk.drain = 1'b0;
        byte_q.push_back(junk);

        // Fill the whole window so that later matches may reach anywhere.
        epos = 0;
        enc_begin();
        repeat (8) tok_lit(8'($urandom));
        while (epos < WINDOW_BYTES + 64)
            tok_match($urandom_range(1, 8), $urandom_range(200, 272));
        tok_escape(0);
        enc_commit(1'b1, 1'b1);

        while (byte_q.size() < TARGET_ITEMS)
        begin
            epos = 0;
            enc_begin();
            cnt = $urandom_range(1, 20);
            repeat (cnt) random_token();
            r = $urandom_range(99);
            if (r < 75)
                tok_escape(0);
            else if (r < 90)
            begin
                // Abandon the stream inside a token that waits for a data byte.
                enc_bit($urandom_range(1));
                if (!ebits[ecnt == 0 ? 15 : ecnt - 1])
                    enc_bit($urandom_range(1));
            end
            enc_commit(1'b1, (streams_built % 6) == 0);
            if (r < 75 && $urandom_range(99) < 30)
            begin
                repeat ($urandom_range(1, 3))
                begin
                    junk.data = 8'($urandom);
                    junk.start = 1'b0;
                    junk.drain = 1'b0;
                    byte_q.push_back(junk);
                end
            end
        end

        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        do @(posedge clk);
        while (byte_q.size() != 0 || in_bus.valid || group_q.size() != 0);
        repeat (200) @(posedge clk);
        if (group_q.size() != 0)
        begin
            $display("%0t: %0d expected result groups never arrived", $time, group_q.size());
            errors++;
        end
        $display("Sent %0d compressed bytes in %0d streams; checked %0d result groups,",
                 bytes_sent, streams_built, groups_seen);
        $display("%0d of them stop reports, with %0d mismatches.", stops_seen, errors);
        if (errors == 0)
            $display("[diet_lz_stream_decompressor_core] OK");
        else
            $display("[diet_lz_stream_decompressor_core] ERROR");
        $finish;
    end

    // ---------------- driver ----------------
    always @(negedge clk)
    begin
        in_item_t it;
        bit       go;
        if (!rst_n)
            in_bus.valid <= 1'b0;
        else if (!(in_bus.valid && !in_fire))
        begin
            go = byte_q.size() != 0 && $urandom_range(99) >= pct_send();
            if (go && byte_q[0].drain && group_q.size() != 0)
                go = 1'b0;
            if (go)
            begin
                it = byte_q.pop_front();
                in_bus.data_byte <= it.data;
                in_bus.stream_start <= it.start;
            end
            in_bus.valid <= go;
        end
    end

    // Result side: random stalls, plus one long hold-off that lets the block fill up.
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            out_bus.ready <= 1'b0;
            hold_left = 0;
            hold_done = 1'b0;
        end
        else if (hold_left > 0)
        begin
            hold_left--;
            out_bus.ready <= 1'b0;
        end
        else if (!hold_done && groups_seen >= 150)
        begin
            hold_done = 1'b1;
            hold_left = 600;
            out_bus.ready <= 1'b0;
        end
        else
            out_bus.ready <= $urandom_range(99) >= pct_recv();
    end

    // ---------------- monitor ----------------
    always @(posedge clk)
    begin
        group_t e;
        in_fire <= rst_n && in_bus.valid && in_bus.ready;
        if (rst_n && in_bus.valid && in_bus.ready)
        begin
            bytes_sent++;
            predict_groups(in_bus.data_byte, in_bus.stream_start);
        end
        if (rst_n && out_bus.valid && out_bus.ready)
        begin
            groups_seen++;
            if (out_bus.stream_end)
                stops_seen++;
            if (group_q.size() == 0)
            begin
                $display("%0t: unexpected result: bytes=%h count=%0d", $time,
                         out_bus.out_bytes, out_bus.byte_count);
                errors++;
            end
            else
            begin
                e = group_q.pop_front();
                if (out_bus.out_bytes !== e.bytes)
                begin
                    $display("%0t: out_bytes expected %h actual %h", $time, e.bytes,
                             out_bus.out_bytes);
                    errors++;
                end
                if (out_bus.byte_count !== e.cnt)
                begin
                    $display("%0t: byte_count expected %0d actual %0d", $time, e.cnt,
                             out_bus.byte_count);
                    errors++;
                end
                if (out_bus.last_of_run !== e.last)
                begin
                    $display("%0t: last_of_run expected %b actual %b", $time, e.last,
                             out_bus.last_of_run);
                    errors++;
                end
                if (out_bus.stream_end !== e.fin)
                begin
                    $display("%0t: stream_end expected %b actual %b", $time, e.fin,
                             out_bus.stream_end);
                    errors++;
                end
                if (out_bus.total_length !== e.total)
                begin
                    $display("%0t: total_length expected %0d actual %0d", $time, e.total,
                             out_bus.total_length);
                    errors++;
                end
            end
        end
    end

    // Watchdog on cycles without any transaction.
    always @(posedge clk)
    begin
        if (!rst_n || (in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready))
            idle_cycles <= 0;
        else if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("%0t: no transaction for %0d cycles", $time, IDLE_LIMIT);
            $display("[diet_lz_stream_decompressor_core] ERROR");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

endmodule

// File: sim.f
hdl/dlz_pkg.sv
hdl/dlz_in_if.sv
hdl/dlz_front.sv
hdl/dlz_queue.sv
hdl/dlz_back.sv
hdl/diet_lz_stream_decompressor_core.sv
test/tb_diet_lz_stream_decompressor_core.sv
